### design/fbw_pkg.sv
// Package for the one-bit frame store window writer.
// Holds shared widths, register indexes, reset values and the transaction structs.
// No dependencies.
package fbw_pkg;

   // Field widths fixed by the block's interface.
   localparam int COORD_W = 9;
   localparam int COLOR_W = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 16;
   localparam int BYTE_W = 8;
   localparam int BIT_SEL_W = 3;

   // Default frame geometry.
   localparam int FRAME_WIDTH_DEFAULT = 400;
   localparam int FRAME_HEIGHT_DEFAULT = 300;

   // Register reset values.
   localparam logic [COORD_W-1:0] START_X_RESET = 9'd0;
   localparam logic [COORD_W-1:0] START_Y_RESET = 9'd0;
   localparam logic [COORD_W-1:0] END_X_RESET = 9'd399;
   localparam logic [COLOR_W-1:0] THRESHOLD_RESET = 16'd32767;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_START_X = 8'd0,
      CSR_WINDOW_START_Y = 8'd1,
      CSR_WINDOW_END_X = 8'd2,
      CSR_COLOR_THRESHOLD = 8'd3
   } csr_index_type;

   // Access modes of a request.
   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_READ = 1'b1
   } mode_type;

   // One pixel access as handed from the cursor unit to the update stage.
   typedef struct packed {
      mode_type mode;
      logic black;
      logic clip;
      logic [BIT_SEL_W-1:0] bit_sel;
   } access_type;

   // One result transaction.
   typedef struct packed {
      logic pixel_bit;
      logic clipped;
   } rsp_type;

endpackage

### design/fbw_if.sv
// Channel interfaces of the frame store window writer: request, response, register write.
// Depends on fbw_pkg for the field widths.

// Pixel access requests.
interface fbw_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic [fbw_pkg::COLOR_W-1:0] pixel_color;
   logic restart;

   modport source (output valid, output mode, output pixel_color, output restart,
                   input ready);
   modport sink (input valid, input mode, input pixel_color, input restart,
                 output ready);
endinterface

// Access results.
interface fbw_rsp_if;
   logic valid;
   logic ready;
   logic pixel_bit;
   logic clipped;

   modport source (output valid, output pixel_bit, output clipped, input ready);
   modport sink (input valid, input pixel_bit, input clipped, output ready);
endinterface

// Configuration register writes.
interface fbw_csr_if;
   logic valid;
   logic ready;
   logic [fbw_pkg::CSR_INDEX_W-1:0] index;
   logic [fbw_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### design/fbw_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Reads return the old contents when the same entry is written in that cycle.
// No dependencies.
module fbw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/fbw_cursor.sv
// Configuration registers, window cursor and byte address generation.
// Depends on fbw_pkg and the register write interface in fbw_if.
module fbw_cursor #(
   parameter int FRAME_WIDTH = fbw_pkg::FRAME_WIDTH_DEFAULT,
   parameter int FRAME_HEIGHT = fbw_pkg::FRAME_HEIGHT_DEFAULT,
   parameter int ADDR_W = 15
) (
   input  logic clock,
   input  logic reset,
   fbw_csr_if.sink csr_ch,
   input  logic accept,
   input  logic req_mode,
   input  logic [fbw_pkg::COLOR_W-1:0] req_color,
   input  logic req_restart,
   output fbw_pkg::access_type access,
   output logic [ADDR_W-1:0] addr
);

   localparam int ROW_BYTES = (FRAME_WIDTH + 7) / 8;
   localparam logic [ADDR_W-1:0] ROW_BYTES_A = ADDR_W'(ROW_BYTES);
   localparam logic [fbw_pkg::COORD_W:0] WIDTH_LIMIT = (fbw_pkg::COORD_W + 1)'(FRAME_WIDTH);
   localparam logic [fbw_pkg::COORD_W:0] HEIGHT_LIMIT =
      (fbw_pkg::COORD_W + 1)'(FRAME_HEIGHT);

   logic [fbw_pkg::COORD_W-1:0] start_x_ff, start_y_ff, end_x_ff;
   logic [fbw_pkg::COLOR_W-1:0] threshold_ff;
   logic [fbw_pkg::COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [fbw_pkg::COORD_W-1:0] eff_col, eff_row;

   assign csr_ch.ready = 1'b1;

   // Register writes; an unknown index is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= fbw_pkg::START_X_RESET;
         start_y_ff <= fbw_pkg::START_Y_RESET;
         end_x_ff <= fbw_pkg::END_X_RESET;
         threshold_ff <= fbw_pkg::THRESHOLD_RESET;
      end else if (csr_ch.valid) begin
         case (fbw_pkg::csr_index_type'(csr_ch.index))
            fbw_pkg::CSR_WINDOW_START_X: start_x_ff <= csr_ch.data[fbw_pkg::COORD_W-1:0];
            fbw_pkg::CSR_WINDOW_START_Y: start_y_ff <= csr_ch.data[fbw_pkg::COORD_W-1:0];
            fbw_pkg::CSR_WINDOW_END_X: end_x_ff <= csr_ch.data[fbw_pkg::COORD_W-1:0];
            fbw_pkg::CSR_COLOR_THRESHOLD: threshold_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Cursor position for this access, after an optional restart.
   always_comb begin
      eff_col = req_restart ? start_x_ff : col_ff;
      eff_row = req_restart ? start_y_ff : row_ff;
   end

   // Advance along the row, wrapping to the start column on the next row.
   always_comb begin
      if (eff_col < end_x_ff) begin
         col_in = eff_col + 1'b1;
         row_in = eff_row;
      end else begin
         col_in = start_x_ff;
         row_in = eff_row + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Classify the access and form the byte address within the frame.
   always_comb begin
      access.mode = fbw_pkg::mode_type'(req_mode);
      access.black = (req_color <= threshold_ff);
      access.clip = ({1'b0, eff_col} >= WIDTH_LIMIT) || ({1'b0, eff_row} >= HEIGHT_LIMIT);
      access.bit_sel = eff_col[fbw_pkg::BIT_SEL_W-1:0];
      addr = ADDR_W'(ADDR_W'(eff_row) * ROW_BYTES_A
             + ADDR_W'(eff_col[fbw_pkg::COORD_W-1:fbw_pkg::BIT_SEL_W]));
   end

endmodule

### design/fbw_rmw.sv
// Read-modify-write stage of the frame store, with write forwarding and the
// post-reset clearing sweep. Depends on fbw_pkg.
module fbw_rmw #(
   parameter int FRAME_WIDTH = fbw_pkg::FRAME_WIDTH_DEFAULT,
   parameter int FRAME_HEIGHT = fbw_pkg::FRAME_HEIGHT_DEFAULT,
   parameter int ADDR_W = 15
) (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  fbw_pkg::access_type access,
   input  logic [ADDR_W-1:0] addr,
   input  logic [fbw_pkg::BYTE_W-1:0] ram_rd_data,
   output logic ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic [fbw_pkg::BYTE_W-1:0] ram_wr_data,
   output logic clearing,
   output logic push,
   output fbw_pkg::rsp_type push_data
);

   localparam int STORE_BYTES = ((FRAME_WIDTH + 7) / 8) * FRAME_HEIGHT;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

   logic clear_ff;
   logic [ADDR_W-1:0] clear_addr_ff;
   logic s1_valid_ff;
   fbw_pkg::access_type s1_acc_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [fbw_pkg::BYTE_W-1:0] fwd_data_ff;
   logic [fbw_pkg::BYTE_W-1:0] cur_byte, new_byte, mask;
   logic do_write;

   // Clearing sweep: one byte per cycle after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == LAST_ADDR) begin
            clear_ff <= 1'b0;
         end
      end
   end

   assign clearing = clear_ff;

   // Access held while the RAM read completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_acc_ff <= access;
      s1_addr_ff <= addr;
   end

   // Use the byte written last cycle when the RAM read raced with it.
   always_comb begin
      cur_byte = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : ram_rd_data;
      mask = 8'h80 >> s1_acc_ff.bit_sel;
      new_byte = s1_acc_ff.black ? (cur_byte | mask) : (cur_byte & ~mask);
      do_write = s1_valid_ff && (s1_acc_ff.mode == fbw_pkg::MODE_WRITE) && !s1_acc_ff.clip;
   end

   // Write port shared between the sweep and pixel updates.
   always_comb begin
      if (clear_ff) begin
         ram_wr_en = 1'b1;
         ram_wr_addr = clear_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en = do_write;
         ram_wr_addr = s1_addr_ff;
         ram_wr_data = new_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= do_write && !clear_ff;
      end
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= new_byte;
   end

   // Result of the access.
   always_comb begin
      push = s1_valid_ff;
      push_data.clipped = s1_acc_ff.clip;
      if (s1_acc_ff.clip) begin
         push_data.pixel_bit = 1'b0;
      end else if (s1_acc_ff.mode == fbw_pkg::MODE_WRITE) begin
         push_data.pixel_bit = s1_acc_ff.black;
      end else begin
         push_data.pixel_bit = |(cur_byte & mask);
      end
   end

endmodule

### design/fbw_rsp_queue.sv
// Two-entry result queue that separates the update stage from the response channel.
// Depends on fbw_pkg and the response interface in fbw_if.
module fbw_rsp_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  fbw_pkg::rsp_type push_data,
   output logic [1:0] count,
   output logic pop,
   fbw_rsp_if.source rsp_ch
);

   fbw_pkg::rsp_type entry_ff [2];
   logic rd_ptr_ff, wr_ptr_ff;
   logic [1:0] count_ff;
   fbw_pkg::rsp_type head;

   assign head = entry_ff[rd_ptr_ff];
   assign rsp_ch.valid = (count_ff != 2'd0);
   assign rsp_ch.pixel_bit = head.pixel_bit;
   assign rsp_ch.clipped = head.clipped;
   assign pop = rsp_ch.valid && rsp_ch.ready;
   assign count = count_ff;

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/mono_framebuffer_window_writer_core.sv
// Top level of the one-bit frame store window writer.
// Depends on fbw_pkg, fbw_if, fbw_ram, fbw_cursor, fbw_rmw and fbw_rsp_queue.
//
// Usage:
//  req_ch carries pixel accesses (mode, pixel_color, restart); rsp_ch returns one
//  transaction per request with the stored pixel_bit and the clipped flag;
//  csr_ch writes the window and threshold registers and is always ready.
//  Write registers only while no request is in flight.
//  Each result is registered in the update stage and then in the response queue
//  before it becomes valid on rsp_ch. Throughput: one request per cycle while
//  req_ch.ready is high. The byte store is a RAM with a registered read; the
//  read-modify-write of back-to-back pixels in the same byte is covered by
//  forwarding the byte written in the previous cycle.
//  Reset: the cursor and registers go to their reset values, then the store is
//  cleared one byte per cycle, ((FRAME_WIDTH + 7) / 8) * FRAME_HEIGHT bytes
//  (15000 by default), during which req_ch.ready stays low.
//  Stall: a two-entry response queue holds results; req_ch.ready drops while
//  clearing and when the queue and the update stage together would overflow.
module mono_framebuffer_window_writer_core #(
   parameter int FRAME_WIDTH = fbw_pkg::FRAME_WIDTH_DEFAULT,
   parameter int FRAME_HEIGHT = fbw_pkg::FRAME_HEIGHT_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   fbw_req_if.sink req_ch,
   fbw_rsp_if.source rsp_ch,
   fbw_csr_if.sink csr_ch
);

   localparam int STORE_BYTES = ((FRAME_WIDTH + 7) / 8) * FRAME_HEIGHT;
   localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   logic accept;
   fbw_pkg::access_type access;
   logic [ADDR_W-1:0] addr;
   logic [fbw_pkg::BYTE_W-1:0] ram_rd_data, ram_wr_data;
   logic ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic clearing, push, pop;
   fbw_pkg::rsp_type push_data;
   logic [1:0] count;
   logic [1:0] load;

   // Admit a request when the store is not clearing and the queue can still take everything in flight.
   always_comb begin
      load = count + {1'b0, push} - {1'b0, pop};
      req_ch.ready = !clearing && (load < 2'd2);
      accept = req_ch.valid && req_ch.ready;
   end

   fbw_cursor #(
      .FRAME_WIDTH(FRAME_WIDTH),
      .FRAME_HEIGHT(FRAME_HEIGHT),
      .ADDR_W(ADDR_W)
   ) u_cursor (
      .clock(clock),
      .reset(reset),
      .csr_ch(csr_ch),
      .accept(accept),
      .req_mode(req_ch.mode),
      .req_color(req_ch.pixel_color),
      .req_restart(req_ch.restart),
      .access(access),
      .addr(addr)
   );

   fbw_ram #(
      .WIDTH(fbw_pkg::BYTE_W),
      .DEPTH(STORE_BYTES)
   ) u_store (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(addr),
      .rd_data(ram_rd_data)
   );

   fbw_rmw #(
      .FRAME_WIDTH(FRAME_WIDTH),
      .FRAME_HEIGHT(FRAME_HEIGHT),
      .ADDR_W(ADDR_W)
   ) u_rmw (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .access(access),
      .addr(addr),
      .ram_rd_data(ram_rd_data),
      .ram_wr_en(ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .clearing(clearing),
      .push(push),
      .push_data(push_data)
   );

   fbw_rsp_queue u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .count(count),
      .pop(pop),
      .rsp_ch(rsp_ch)
   );

endmodule
